// ===== rtl/c64bd_pkg.sv =====
// ----------------------------------------------------------------------------
// c64bd_pkg
// Shared types and constants of the C64 bank switched bus decoder.
// ----------------------------------------------------------------------------
package c64bd_pkg;

   localparam int ADDR_BITS = 16;
   localparam int MEM_DEPTH = 1 << ADDR_BITS;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   // bus functions
   localparam logic [2:0] FN_CODE_READ = 3'd0;
   localparam logic [2:0] FN_DATA_READ = 3'd1;
   localparam logic [2:0] FN_WRITE     = 3'd2;
   localparam logic [2:0] FN_JUMP      = 3'd3;
   localparam logic [2:0] FN_INIT_BANK = 3'd4;
   localparam logic [2:0] FN_LOAD_RAM  = 3'd5;
   localparam logic [2:0] FN_LOAD_ROM  = 3'd6;

   // environment modes
   localparam logic [1:0] ENV_SINGLE      = 2'd0;
   localparam logic [1:0] ENV_TRANSPARENT = 2'd1;
   localparam logic [1:0] ENV_BANKED      = 2'd2;

   // register indexes (paddr bit 2)
   localparam logic CSR_MODE_IDX = 1'b0;
   localparam logic CSR_PAGE_IDX = 1'b1;

   localparam logic [1:0] MODE_RESET = ENV_BANKED;
   localparam logic [7:0] PAGE_RESET = 8'h00;
   localparam logic [7:0] BANK_RESET = 8'h07;

   localparam logic [ADDR_BITS-1:0] SID_MASK   = 16'hfc1f;
   localparam logic [ADDR_BITS-1:0] SID_BASE   = 16'hd400;
   localparam logic [7:0]           SID_PAGE   = 8'hd4;
   localparam logic [7:0]           XSID_FIRST = 8'h1d;
   localparam logic [11:0]          CIA_PAGE   = 12'hdc0;
   localparam logic [ADDR_BITS-1:0] BASIC_BASE = 16'ha000;
   localparam logic [ADDR_BITS-1:0] IO_BASE    = 16'hd000;
   localparam logic [ADDR_BITS-1:0] KERN_BASE  = 16'he000;
   localparam logic [ADDR_BITS-1:0] BANK_ADDR  = 16'h0001;

   typedef enum logic [1:0] {
      SRC_ZERO,
      SRC_BANK,
      SRC_RAM,
      SRC_ROM
   } src_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_WRITE2,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [2:0]           func;
      logic [ADDR_BITS-1:0] address;
      logic [7:0]           write_data;
      logic                 use_cache;
   } req_type;

   typedef struct packed {
      logic [7:0]           read_data;
      logic                 device_read_pending;
      logic                 cia_select;
      logic                 sid_one_select;
      logic                 sid_two_select;
      logic                 xsid_select;
      logic [15:0]          device_address;
      logic [7:0]           sid_two_register;
      logic                 jump_allowed;
      logic [7:0]           bank_value;
   } rsp_type;

   typedef struct packed {
      logic                 pend;
      logic                 cia;
      logic                 s1;
      logic                 s2;
      logic                 xs;
      logic [15:0]          dev_addr;
      logic [7:0]           s2_reg;
      logic                 jump;
      src_type              rd_src;
      logic [ADDR_BITS-1:0] rd_addr;
      logic                 wr_en;
      logic                 wr_rom;
      logic [ADDR_BITS-1:0] wr_addr;
      logic                 wr2_en;
      logic [ADDR_BITS-1:0] wr2_addr;
      logic [7:0]           wr_data;
      logic                 bank_we;
      logic [7:0]           bank_data;
   } dec_type;

endpackage

// ===== rtl/c64_bank_switched_bus_decoder.sv =====
// ----------------------------------------------------------------------------
// c64_bank_switched_bus_decoder
// C64 bus decoder: 64K RAM, 64K ROM/shadow store, bank register at $01.
//
//   channel   handshake              payload
//   request   start / busy           req_item  (req_type)
//   response  rsp_strobe             rsp_item  (rsp_type)
//   config    psel/penable/pwrite    paddr, pwdata, prdata, pready
//
// An item passes through an access state for the store access and a result
// state with the result beat on the outputs; the next item is taken during
// the result state. A cached SID write that hits both SID images also passes
// through a second write state, since each store has one write port.
// Reset clears the control state, the bank register and the registers; the
// stores are not cleared. The receiver cannot stall: each beat lasts one cycle.
// ----------------------------------------------------------------------------
module c64_bank_switched_bus_decoder
   import c64bd_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  req_type                  req_item,
   output logic                     rsp_strobe,
   output rsp_type                  rsp_item,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   state_type            state_ff, state_in;
   req_type              req_ff;
   logic [1:0]           mode_ff;
   logic [7:0]           page_ff;
   logic [7:0]           bank_ff;
   rsp_type              res_ff;
   src_type              src_ff;
   logic [7:0]           ram_q_ff;
   logic [7:0]           rom_q_ff;
   logic [7:0]           ram_mem [0:MEM_DEPTH-1];
   logic [7:0]           rom_mem [0:MEM_DEPTH-1];
   dec_type              dec;
   logic                 accept;
   logic                 exec;
   logic                 csr_we;
   logic                 ram_re, rom_re;
   logic                 ram_we, rom_we;
   logic [ADDR_BITS-1:0] wr_addr;

   c64bd_decode u_decode (
      .req  (req_ff),
      .mode (mode_ff),
      .page (page_ff),
      .bank (bank_ff),
      .dec  (dec)
   );

   assign busy   = (state_ff == ST_EXEC) || (state_ff == ST_WRITE2);
   assign accept = start && !busy;
   assign exec   = (state_ff == ST_EXEC);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      rsp_strobe = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = dec.wr2_en ? ST_WRITE2 : ST_RESP;
         end
         ST_WRITE2: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            rsp_strobe = 1'b1;
            state_in = start ? ST_EXEC : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_item;
      end
   end

   // registers
   assign pready = 1'b1;
   assign csr_we = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_RESET;
         page_ff <= PAGE_RESET;
      end else if (csr_we) begin
         if (paddr[2] == CSR_MODE_IDX) begin
            mode_ff <= pwdata[1:0];
         end else begin
            page_ff <= pwdata[7:0];
         end
      end
   end

   always_comb begin
      case (paddr[2])
         CSR_MODE_IDX: prdata = {{(CSR_DATA_BITS-2){1'b0}}, mode_ff};
         CSR_PAGE_IDX: prdata = {{(CSR_DATA_BITS-8){1'b0}}, page_ff};
         default:      prdata = '0;
      endcase
   end

   // bank register
   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff <= BANK_RESET;
      end else if (exec && dec.bank_we) begin
         bank_ff <= dec.bank_data;
      end
   end

   // store ports
   assign ram_re  = exec && (dec.rd_src == SRC_RAM);
   assign rom_re  = exec && (dec.rd_src == SRC_ROM);
   assign ram_we  = ((exec && dec.wr_en) || (state_ff == ST_WRITE2)) && !dec.wr_rom;
   assign rom_we  = ((exec && dec.wr_en) || (state_ff == ST_WRITE2)) && dec.wr_rom;
   assign wr_addr = (state_ff == ST_WRITE2) ? dec.wr2_addr : dec.wr_addr;

   always_ff @(posedge clock) begin
      if (ram_we) begin
         ram_mem[wr_addr] <= dec.wr_data;
      end
      if (ram_re) begin
         ram_q_ff <= ram_mem[dec.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (rom_we) begin
         rom_mem[wr_addr] <= dec.wr_data;
      end
      if (rom_re) begin
         rom_q_ff <= rom_mem[dec.rd_addr];
      end
   end

   // result hold
   always_ff @(posedge clock) begin
      if (exec) begin
         src_ff                    <= dec.rd_src;
         res_ff.read_data          <= 8'h00;
         res_ff.device_read_pending <= dec.pend;
         res_ff.cia_select         <= dec.cia;
         res_ff.sid_one_select     <= dec.s1;
         res_ff.sid_two_select     <= dec.s2;
         res_ff.xsid_select        <= dec.xs;
         res_ff.device_address     <= dec.dev_addr;
         res_ff.sid_two_register   <= dec.s2_reg;
         res_ff.jump_allowed       <= dec.jump;
         res_ff.bank_value         <= 8'h00;
      end
   end

   always_comb begin
      rsp_item = res_ff;
      rsp_item.bank_value = bank_ff;
      case (src_ff)
         SRC_ZERO: rsp_item.read_data = 8'h00;
         SRC_BANK: rsp_item.read_data = bank_ff;
         SRC_RAM:  rsp_item.read_data = ram_q_ff;
         SRC_ROM:  rsp_item.read_data = rom_q_ff;
         default:  rsp_item.read_data = 8'h00;
      endcase
   end

   a_one_store_written: assert property (@(posedge clock) disable iff (reset)
      !(ram_we && rom_we))
      else $error("both stores written in one cycle");

   a_beat_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(state_ff) == ST_EXEC || $past(state_ff) == ST_WRITE2))
      else $error("result beat without a preceding access");

   a_accept_runs: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy && (state_ff == ST_EXEC))
      else $error("accepted item not executed");

   a_second_write_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE2) |=> rsp_strobe)
      else $error("second write not followed by a result beat");

   a_bank_changes_in_exec: assert property (@(posedge clock) disable iff (reset)
      ($past(!reset) && (bank_ff != $past(bank_ff))) |-> $past(state_ff == ST_EXEC))
      else $error("bank register changed outside an access");

endmodule

// ===== rtl/c64bd_decode.sv =====
// ----------------------------------------------------------------------------
// c64bd_decode
// Address decode of one bus access: store port control, device flags, bank.
// ----------------------------------------------------------------------------
module c64bd_decode
   import c64bd_pkg::*;
(
   input  req_type    req,
   input  logic [1:0] mode,
   input  logic [7:0] page,
   input  logic [7:0] bank,
   output dec_type    dec
);

   logic [ADDR_BITS-1:0] a;
   logic [ADDR_BITS-1:0] t;
   logic [3:0]           nib;
   logic                 io_region;
   logic                 xs_hit;
   logic                 s2_hit;
   logic                 cia_hit;
   logic                 is_one;
   logic                 sh_rom;
   src_type              sh_src;
   logic                 basic;
   logic                 io_on;
   logic                 kernal;
   logic [7:0]           init_val;
   dec_type              io_rd;
   dec_type              io_wr;

   assign a         = req.address;
   assign t         = a & SID_MASK;
   assign nib       = a[15:12];
   assign io_region = (t[15:8] == SID_PAGE);
   assign xs_hit    = (t[7:0] >= XSID_FIRST);
   assign s2_hit    = (a[15:8] == page);
   assign cia_hit   = (a[15:4] == CIA_PAGE);
   assign is_one    = (a == BANK_ADDR);
   assign sh_rom    = (mode != ENV_SINGLE);
   assign sh_src    = sh_rom ? SRC_ROM : SRC_RAM;
   assign basic     = (bank[1:0] == 2'b11);
   assign io_on     = (bank[2:0] > 3'd4);
   assign kernal    = bank[1];

   always_comb begin
      io_rd = '0;
      io_rd.wr_rom = sh_rom;
      io_rd.wr_data = req.write_data;
      if (!io_region) begin
         if (is_one) begin
            io_rd.rd_src = SRC_BANK;
         end else if (cia_hit) begin
            io_rd.pend = 1'b1;
            io_rd.cia = 1'b1;
            io_rd.dev_addr = {12'h000, a[3:0]};
         end else begin
            io_rd.rd_src = sh_src;
            io_rd.rd_addr = a;
         end
      end else if (xs_hit) begin
         io_rd.pend = 1'b1;
         io_rd.xs = 1'b1;
         io_rd.dev_addr = a;
      end else if (s2_hit) begin
         if (req.use_cache) begin
            io_rd.rd_src = sh_src;
            io_rd.rd_addr = a;
         end else begin
            io_rd.pend = 1'b1;
            io_rd.s2 = 1'b1;
            io_rd.s2_reg = a[7:0];
         end
      end else if (req.use_cache) begin
         io_rd.rd_src = sh_src;
         io_rd.rd_addr = t;
      end else begin
         io_rd.pend = 1'b1;
         io_rd.s1 = 1'b1;
         io_rd.dev_addr = {8'h00, t[7:0]};
      end
   end

   always_comb begin
      io_wr = '0;
      io_wr.wr_rom = sh_rom;
      io_wr.wr_data = req.write_data;
      if (!io_region) begin
         if (is_one) begin
            io_wr.bank_we = 1'b1;
            io_wr.bank_data = req.write_data;
         end else if (cia_hit) begin
            io_wr.cia = 1'b1;
            io_wr.dev_addr = {12'h000, a[3:0]};
         end else begin
            io_wr.wr_en = 1'b1;
            io_wr.wr_addr = a;
         end
      end else if (xs_hit) begin
         io_wr.xs = 1'b1;
         io_wr.dev_addr = a - SID_BASE;
      end else if (s2_hit) begin
         io_wr.s2 = 1'b1;
         io_wr.s2_reg = a[7:0];
         if (req.use_cache) begin
            io_wr.wr_en = 1'b1;
            io_wr.wr_addr = a;
            if (page == SID_PAGE) begin
               io_wr.s1 = 1'b1;
               io_wr.dev_addr = {8'h00, t[7:0]};
               io_wr.wr2_en = 1'b1;
               io_wr.wr2_addr = t;
            end
         end
      end else begin
         io_wr.s1 = 1'b1;
         io_wr.dev_addr = {8'h00, t[7:0]};
         if (req.use_cache) begin
            io_wr.wr_en = 1'b1;
            io_wr.wr_addr = t;
         end
      end
   end

   always_comb begin
      if (mode == ENV_SINGLE) begin
         init_val = 8'h04;
      end else if (a < BASIC_BASE) begin
         init_val = 8'h07;
      end else if (a < IO_BASE) begin
         init_val = 8'h06;
      end else if (a >= KERN_BASE) begin
         init_val = 8'h05;
      end else begin
         init_val = 8'h04;
      end
   end

   always_comb begin
      dec = '0;
      dec.wr_data = req.write_data;
      dec.rd_addr = a;
      dec.wr_addr = a;
      case (req.func)
         FN_CODE_READ: begin
            dec.rd_src = SRC_RAM;
         end
         FN_DATA_READ: begin
            if (mode == ENV_SINGLE) begin
               dec = io_rd;
            end else if (mode == ENV_TRANSPARENT) begin
               if (nib == 4'hd && io_on) begin
                  dec = io_rd;
               end else begin
                  dec.rd_src = SRC_RAM;
               end
            end else if (a < BASIC_BASE) begin
               dec.rd_src = is_one ? SRC_BANK : SRC_RAM;
            end else if (nib == 4'ha || nib == 4'hb) begin
               dec.rd_src = basic ? SRC_ROM : SRC_RAM;
            end else if (nib == 4'hc) begin
               dec.rd_src = SRC_RAM;
            end else if (nib == 4'hd) begin
               if (io_on) begin
                  dec = io_rd;
               end else begin
                  dec.rd_src = SRC_RAM;
               end
            end else begin
               dec.rd_src = kernal ? SRC_ROM : SRC_RAM;
            end
         end
         FN_WRITE: begin
            if (mode == ENV_SINGLE) begin
               dec = io_wr;
            end else if (is_one) begin
               dec.bank_we = 1'b1;
               dec.bank_data = req.write_data;
            end else if (nib == 4'hd && io_on) begin
               dec = io_wr;
            end else begin
               dec.wr_en = 1'b1;
            end
         end
         FN_JUMP: begin
            if (mode == ENV_BANKED) begin
               if (a < BASIC_BASE || nib == 4'hc) begin
                  dec.jump = 1'b1;
               end else if (nib == 4'ha || nib == 4'hb) begin
                  dec.jump = !basic;
               end else if (nib == 4'hd) begin
                  dec.jump = !io_on;
               end else begin
                  dec.jump = !kernal;
               end
            end else if (mode == ENV_TRANSPARENT) begin
               dec.jump = !(a >= IO_BASE && kernal);
            end else begin
               dec.jump = 1'b1;
            end
         end
         FN_INIT_BANK: begin
            dec.bank_we = 1'b1;
            dec.bank_data = init_val;
            dec.wr_en = 1'b1;
            dec.wr_addr = BANK_ADDR;
            dec.wr_data = init_val;
         end
         FN_LOAD_RAM: begin
            dec.wr_en = 1'b1;
         end
         FN_LOAD_ROM: begin
            dec.wr_en = 1'b1;
            dec.wr_rom = sh_rom;
         end
         default: begin
            dec.jump = 1'b0;
         end
      endcase
   end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Bus access test of the C64 bank switched bus decoder. A class keeps its own
// image of both stores, the bank register and the two control registers. It
// works out the beat that each accepted access must produce and compares it,
// field by field, with the beats the block sends back. Directed accesses come
// first, then random accesses over a set of memory maps, with random gaps.
// ----------------------------------------------------------------------------
module tb;
   import c64bd_pkg::*;

   typedef enum logic [1:0] {
      NO_STORE,
      RAM_STORE,
      ROM_STORE
   } store_sel;

   typedef struct packed {
      rsp_type         beat;
      store_sel        rd_store;
      logic [15:0]     rd_addr;
      store_sel        wr_store;
      logic [1:0]      n_wr;
      logic [15:0]     wr_addr0;
      logic [15:0]     wr_addr1;
      logic [7:0]      wr_data;
      logic            bank_we;
      logic [7:0]      bank_data;
   } access_effect;

   class access_ledger;
      bit [7:0]   ram_img [MEM_DEPTH];
      bit [7:0]   rom_img [MEM_DEPTH];
      bit         ram_set [MEM_DEPTH];
      bit         rom_set [MEM_DEPTH];
      logic [7:0] bank;
      logic [1:0] env;
      logic [7:0] sid2_page;
      rsp_type    due_beats [$];
      int         errors;

      function new();
         bank = BANK_RESET;
         env = MODE_RESET;
         sid2_page = PAGE_RESET;
         errors = 0;
      endfunction

      function bit basic_on();
         return bank[1:0] == 2'b11;
      endfunction

      function bit io_on();
         return bank[2:0] > 3'd4;
      endfunction

      function bit kernal_on();
         return bank[1];
      endfunction

      function store_sel shadow_store();
         return (env == ENV_SINGLE) ? RAM_STORE : ROM_STORE;
      endfunction

      function void put_write(inout access_effect e, input store_sel s, input logic [15:0] a);
         e.wr_store = s;
         if (e.n_wr == 0) e.wr_addr0 = a;
         else e.wr_addr1 = a;
         e.n_wr = e.n_wr + 2'd1;
      endfunction

      function void put_read(inout access_effect e, input store_sel s, input logic [15:0] a);
         e.rd_store = s;
         e.rd_addr = a;
      endfunction

      function void io_read(inout access_effect e, input logic [15:0] a, input logic cache);
         logic [15:0] t;
         t = a & SID_MASK;
         if (t[15:8] != SID_PAGE) begin
            if (a == BANK_ADDR) begin
               e.beat.read_data = bank;
            end else if (a[15:4] == CIA_PAGE) begin
               e.beat.device_read_pending = 1'b1;
               e.beat.cia_select = 1'b1;
               e.beat.device_address = {12'h000, a[3:0]};
            end else begin
               put_read(e, shadow_store(), a);
            end
         end else if (t[7:0] >= XSID_FIRST) begin
            e.beat.device_read_pending = 1'b1;
            e.beat.xsid_select = 1'b1;
            e.beat.device_address = a;
         end else if (a[15:8] == sid2_page) begin
            if (cache) begin
               put_read(e, shadow_store(), a);
            end else begin
               e.beat.device_read_pending = 1'b1;
               e.beat.sid_two_select = 1'b1;
               e.beat.sid_two_register = a[7:0];
            end
         end else if (cache) begin
            put_read(e, shadow_store(), t);
         end else begin
            e.beat.device_read_pending = 1'b1;
            e.beat.sid_one_select = 1'b1;
            e.beat.device_address = {8'h00, t[7:0]};
         end
      endfunction

      function void io_write(inout access_effect e, input logic [15:0] a, input logic cache);
         logic [15:0] t;
         logic        hit2;
         t = a & SID_MASK;
         hit2 = (a[15:8] == sid2_page);
         if (t[15:8] != SID_PAGE) begin
            if (a == BANK_ADDR) begin
               e.bank_we = 1'b1;
               e.bank_data = e.wr_data;
            end else if (a[15:4] == CIA_PAGE) begin
               e.beat.cia_select = 1'b1;
               e.beat.device_address = {12'h000, a[3:0]};
            end else begin
               put_write(e, shadow_store(), a);
            end
         end else if (t[7:0] >= XSID_FIRST) begin
            e.beat.xsid_select = 1'b1;
            e.beat.device_address = a - SID_BASE;
         end else begin
            if (hit2) begin
               e.beat.sid_two_select = 1'b1;
               e.beat.sid_two_register = a[7:0];
               if (cache) put_write(e, shadow_store(), a);
            end
            if (!hit2 || (cache && sid2_page == SID_PAGE)) begin
               e.beat.sid_one_select = 1'b1;
               e.beat.device_address = {8'h00, t[7:0]};
               if (cache) put_write(e, shadow_store(), t);
            end
         end
      endfunction

      function access_effect decode_access(req_type r);
         access_effect e;
         logic [15:0]  a;
         logic [7:0]   v;
         e = '0;
         a = r.address;
         e.wr_data = r.write_data;
         case (r.func)
            FN_CODE_READ: put_read(e, RAM_STORE, a);
            FN_DATA_READ: begin
               if (env == ENV_SINGLE) begin
                  io_read(e, a, r.use_cache);
               end else if (env == ENV_TRANSPARENT) begin
                  if (a >= IO_BASE && a < KERN_BASE && io_on()) io_read(e, a, r.use_cache);
                  else put_read(e, RAM_STORE, a);
               end else if (a < BASIC_BASE) begin
                  if (a == BANK_ADDR) e.beat.read_data = bank;
                  else put_read(e, RAM_STORE, a);
               end else if (a < 16'hc000) begin
                  put_read(e, basic_on() ? ROM_STORE : RAM_STORE, a);
               end else if (a < IO_BASE) begin
                  put_read(e, RAM_STORE, a);
               end else if (a < KERN_BASE) begin
                  if (io_on()) io_read(e, a, r.use_cache);
                  else put_read(e, RAM_STORE, a);
               end else begin
                  put_read(e, kernal_on() ? ROM_STORE : RAM_STORE, a);
               end
            end
            FN_WRITE: begin
               if (env == ENV_SINGLE) begin
                  io_write(e, a, r.use_cache);
               end else if (a == BANK_ADDR) begin
                  e.bank_we = 1'b1;
                  e.bank_data = r.write_data;
               end else if (a >= IO_BASE && a < KERN_BASE && io_on()) begin
                  io_write(e, a, r.use_cache);
               end else begin
                  put_write(e, RAM_STORE, a);
               end
            end
            FN_JUMP: begin
               if (env == ENV_SINGLE) e.beat.jump_allowed = 1'b1;
               else if (env == ENV_TRANSPARENT)
                  e.beat.jump_allowed = !(a >= IO_BASE && kernal_on());
               else if (a < BASIC_BASE || (a >= 16'hc000 && a < IO_BASE))
                  e.beat.jump_allowed = 1'b1;
               else if (a < 16'hc000) e.beat.jump_allowed = !basic_on();
               else if (a < KERN_BASE) e.beat.jump_allowed = !io_on();
               else e.beat.jump_allowed = !kernal_on();
            end
            FN_INIT_BANK: begin
               if (env == ENV_SINGLE) v = 8'd4;
               else if (a < BASIC_BASE) v = 8'd7;
               else if (a < IO_BASE) v = 8'd6;
               else if (a >= KERN_BASE) v = 8'd5;
               else v = 8'd4;
               e.bank_we = 1'b1;
               e.bank_data = v;
               e.wr_data = v;
               put_write(e, RAM_STORE, BANK_ADDR);
            end
            FN_LOAD_RAM: put_write(e, RAM_STORE, a);
            FN_LOAD_ROM: put_write(e, shadow_store(), a);
            default: ;
         endcase
         return e;
      endfunction

      // turn a read of a never-written entry into a load of that entry
      function req_type legalize(req_type r);
         access_effect e;
         req_type      f;
         e = decode_access(r);
         f = r;
         if ((e.rd_store == RAM_STORE && !ram_set[e.rd_addr]) ||
             (e.rd_store == ROM_STORE && !rom_set[e.rd_addr])) begin
            f.func = (e.rd_store == RAM_STORE) ? FN_LOAD_RAM : FN_LOAD_ROM;
            f.address = e.rd_addr;
            f.write_data = 8'($urandom);
         end
         return f;
      endfunction

      function void take_access(req_type r);
         access_effect e;
         logic [15:0]  wa;
         e = decode_access(r);
         if (e.rd_store == RAM_STORE) e.beat.read_data = ram_img[e.rd_addr];
         else if (e.rd_store == ROM_STORE) e.beat.read_data = rom_img[e.rd_addr];
         for (int k = 0; k < e.n_wr; k++) begin
            wa = (k == 0) ? e.wr_addr0 : e.wr_addr1;
            if (e.wr_store == RAM_STORE) begin
               ram_img[wa] = e.wr_data;
               ram_set[wa] = 1'b1;
            end else begin
               rom_img[wa] = e.wr_data;
               rom_set[wa] = 1'b1;
            end
         end
         if (e.bank_we) bank = e.bank_data;
         e.beat.bank_value = bank;
         due_beats.push_back(e.beat);
      endfunction

      function void cmp(string name, logic [15:0] want, logic [15:0] seen);
         if (seen !== want) begin
            $error("%s: expected %0h, got %0h", name, want, seen);
            errors++;
         end
      endfunction

      function void match_beat(rsp_type got);
         rsp_type want;
         if (due_beats.size() == 0) begin
            $error("result beat with nothing due");
            errors++;
            return;
         end
         want = due_beats.pop_front();
         cmp("read_data", 16'(want.read_data), 16'(got.read_data));
         cmp("device_read_pending", 16'(want.device_read_pending),
             16'(got.device_read_pending));
         cmp("cia_select", 16'(want.cia_select), 16'(got.cia_select));
         cmp("sid_one_select", 16'(want.sid_one_select), 16'(got.sid_one_select));
         cmp("sid_two_select", 16'(want.sid_two_select), 16'(got.sid_two_select));
         cmp("xsid_select", 16'(want.xsid_select), 16'(got.xsid_select));
         cmp("device_address", want.device_address, got.device_address);
         cmp("sid_two_register", 16'(want.sid_two_register), 16'(got.sid_two_register));
         cmp("jump_allowed", 16'(want.jump_allowed), 16'(got.jump_allowed));
         cmp("bank_value", 16'(want.bank_value), 16'(got.bank_value));
      endfunction

      function int pending();
         return due_beats.size();
      endfunction
   endclass

   localparam logic [CSR_ADDR_BITS-1:0] MODE_ADDR = {CSR_MODE_IDX, 2'b00};
   localparam logic [CSR_ADDR_BITS-1:0] PAGE_ADDR = {CSR_PAGE_IDX, 2'b00};
   localparam int HOT_COUNT = 64;
   localparam int PHASES = 8;
   localparam int PHASE_ITEMS = 210;
   localparam int WATCHDOG_LIMIT = 1000;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   req_type                  req_item = '0;
   logic                     rsp_strobe;
   rsp_type                  rsp_item;
   logic                     psel = 1'b0;
   logic                     penable = 1'b0;
   logic                     pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] paddr = '0;
   logic [CSR_DATA_BITS-1:0] pwdata = '0;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;

   access_ledger ledger;
   logic [15:0]  hot_addr [HOT_COUNT];
   int           quiet_cycles = 0;

   c64_bank_switched_bus_decoder DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) ledger.match_beat(rsp_item);
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (psel && penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic csr_cycle(bit wr, logic [CSR_ADDR_BITS-1:0] addr, logic [31:0] data,
                            string name);
      @(negedge clock);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = wr;
      paddr = addr;
      pwdata = data;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      if (!wr && prdata !== data) begin
         $error("%s: expected %0h, got %0h", name, data, prdata);
         ledger.errors++;
      end
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   task automatic set_map(logic [1:0] mode, logic [7:0] page);
      csr_cycle(1'b1, MODE_ADDR, 32'(mode), "environment_mode");
      csr_cycle(1'b0, MODE_ADDR, 32'(mode), "environment_mode");
      csr_cycle(1'b1, PAGE_ADDR, 32'(page), "second_sid_page");
      csr_cycle(1'b0, PAGE_ADDR, 32'(page), "second_sid_page");
      ledger.env = mode;
      ledger.sid2_page = page;
   endtask

   task automatic send(req_type r);
      @(negedge clock);
      start = 1'b1;
      req_item = r;
      do @(posedge clock); while (busy);
      ledger.take_access(r);
   endtask

   task automatic pause(int n);
      repeat (n) begin
         @(negedge clock);
         start = 1'b0;
      end
   endtask

   // hold off until every due beat is back, then let the pipe settle
   task automatic drain();
      @(negedge clock);
      start = 1'b0;
      while (ledger.pending() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   function automatic req_type mk(logic [2:0] f, logic [15:0] a, logic [7:0] d, logic c);
      req_type r;
      r.func = f;
      r.address = a;
      r.write_data = d;
      r.use_cache = c;
      return r;
   endfunction

   function automatic req_type random_access();
      req_type     r;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      r.func = (pick < 15) ? FN_CODE_READ :
               (pick < 45) ? FN_DATA_READ :
               (pick < 70) ? FN_WRITE :
               (pick < 80) ? FN_JUMP :
               (pick < 85) ? FN_INIT_BANK :
               (pick < 93) ? FN_LOAD_RAM : FN_LOAD_ROM;
      if ($urandom_range(0, 6) == 0) r.address = 16'($urandom_range(0, 65535));
      else r.address = hot_addr[$urandom_range(0, HOT_COUNT - 1)];
      if (r.func == FN_WRITE && $urandom_range(0, 7) == 0) r.address = BANK_ADDR;
      r.write_data = 8'($urandom);
      r.use_cache = 1'($urandom_range(0, 1));
      return r;
   endfunction

   initial begin
      logic [1:0] mode_plan [PHASES];
      logic [7:0] page_plan [PHASES];
      ledger = new();
      for (int k = 0; k < HOT_COUNT; k++) begin
         if (k < 12) hot_addr[k] = 16'($urandom_range(0, 65535));
         else if (k < 20) hot_addr[k] = BASIC_BASE + 16'($urandom_range(0, 16'h1fff));
         else if (k < 24) hot_addr[k] = 16'hc000 + 16'($urandom_range(0, 16'h0fff));
         else if (k < 32) hot_addr[k] = KERN_BASE + 16'($urandom_range(0, 16'h1fff));
         else if (k < 48) hot_addr[k] = SID_BASE + 16'($urandom_range(0, 16'h03ff));
         else if (k < 52) hot_addr[k] = {CIA_PAGE, 4'h0} + 16'($urandom_range(0, 16'h1f));
         else if (k < 58) hot_addr[k] = IO_BASE + 16'($urandom_range(0, 16'h0fff));
         else hot_addr[k] = 16'($urandom_range(0, 16'h00ff));
      end
      hot_addr[60] = 16'h0000;
      hot_addr[61] = BANK_ADDR;
      hot_addr[62] = 16'hffff;
      hot_addr[63] = 16'hd41d;
      mode_plan = '{ENV_TRANSPARENT, ENV_BANKED, ENV_SINGLE, ENV_BANKED,
                    ENV_TRANSPARENT, ENV_SINGLE, ENV_BANKED, ENV_BANKED};
      page_plan = '{8'hd5, 8'hff, SID_PAGE, SID_PAGE, 8'h00, 8'hd6, 8'hd7, 8'h00};
      mode_plan[6] = 2'($urandom_range(0, 2));
      mode_plan[7] = 2'($urandom_range(0, 2));
      page_plan[7] = ($urandom_range(0, 1) == 0) ? 8'($urandom) :
                     SID_PAGE + 8'($urandom_range(0, 3));

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      csr_cycle(1'b0, MODE_ADDR, 32'(MODE_RESET), "environment_mode");
      csr_cycle(1'b0, PAGE_ADDR, 32'(PAGE_RESET), "second_sid_page");

      set_map(ENV_BANKED, SID_PAGE);
      send(ledger.legalize(mk(FN_LOAD_RAM, 16'h0000, 8'h00, 1'b0)));
      send(ledger.legalize(mk(FN_LOAD_RAM, 16'hffff, 8'hff, 1'b1)));
      send(ledger.legalize(mk(FN_LOAD_ROM, 16'hffff, 8'h5a, 1'b0)));
      send(ledger.legalize(mk(FN_CODE_READ, 16'hffff, 8'h00, 1'b0)));
      send(ledger.legalize(mk(FN_DATA_READ, 16'hffff, 8'h00, 1'b0)));
      send(ledger.legalize(mk(FN_JUMP, 16'hffff, 8'h00, 1'b0)));
      send(ledger.legalize(mk(FN_JUMP, 16'h0000, 8'h00, 1'b0)));
      send(ledger.legalize(mk(FN_DATA_READ, BANK_ADDR, 8'h00, 1'b0)));
      // cached write that lands in both SID images
      send(ledger.legalize(mk(FN_WRITE, SID_BASE, 8'h3c, 1'b1)));
      send(ledger.legalize(mk(FN_DATA_READ, SID_BASE, 8'h00, 1'b1)));
      send(ledger.legalize(mk(FN_DATA_READ, 16'hd41d, 8'h00, 1'b0)));
      send(ledger.legalize(mk(FN_WRITE, 16'hd41f, 8'h81, 1'b0)));
      send(ledger.legalize(mk(FN_DATA_READ, 16'hdc05, 8'h00, 1'b0)));
      send(ledger.legalize(mk(FN_WRITE, 16'hdc0f, 8'h11, 1'b0)));
      send(ledger.legalize(mk(FN_DATA_READ, 16'hd501, 8'h00, 1'b0)));
      send(ledger.legalize(mk(FN_INIT_BANK, KERN_BASE, 8'h00, 1'b0)));
      send(ledger.legalize(mk(FN_INIT_BANK, 16'h0000, 8'h00, 1'b0)));
      send(ledger.legalize(mk(FN_INIT_BANK, BASIC_BASE, 8'h00, 1'b0)));
      send(ledger.legalize(mk(FN_INIT_BANK, IO_BASE, 8'h00, 1'b0)));
      send(ledger.legalize(mk(FN_WRITE, BANK_ADDR, 8'hff, 1'b0)));
      drain();

      // single store: a ROM load must show up in RAM
      set_map(ENV_SINGLE, 8'hff);
      send(ledger.legalize(mk(FN_LOAD_ROM, 16'h1234, 8'ha5, 1'b0)));
      send(ledger.legalize(mk(FN_CODE_READ, 16'h1234, 8'h00, 1'b0)));
      send(ledger.legalize(mk(FN_INIT_BANK, 16'hffff, 8'h00, 1'b0)));
      send(ledger.legalize(mk(FN_DATA_READ, BANK_ADDR, 8'h00, 1'b0)));

      for (int ph = 0; ph < PHASES; ph++) begin
         drain();
         set_map(mode_plan[ph], page_plan[ph]);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (ph != PHASES - 1 && $urandom_range(0, 5) == 0) pause($urandom_range(1, 9));
            send(ledger.legalize(random_access()));
         end
      end
      drain();

      if (ledger.errors == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/c64bd_pkg.sv
rtl/c64bd_decode.sv
rtl/c64_bank_switched_bus_decoder.sv
test/tb.sv
